### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, removed when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

### hdl/bcst_pkg.sv
// ---------------------------------------------------------------------------
// bcst_pkg
// Shared types and constants of the coulomb counting charge tracker.
// ---------------------------------------------------------------------------
package bcst_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CAP_W     = 16;
    localparam int unsigned PM_W      = 10;
    localparam int unsigned FUNC_W    = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned RATIO_W   = 14;

    localparam logic [CAP_W-1:0]   PERMILLE  = 16'd1000;
    localparam logic [CAP_W-1:0]   RATIO_ONE = 16'd10000;
    localparam logic [PM_W-1:0]    PM_FULL   = 10'd1000;

    localparam logic [FUNC_W-1:0] FN_INIT       = 3'd0;
    localparam logic [FUNC_W-1:0] FN_TICK       = 3'd1;
    localparam logic [FUNC_W-1:0] FN_CORR_SOC   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CORR_TOT   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CORR_TOT_L = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOC_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ST_REM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ST_TOT   = 3'd4;

    typedef struct packed {
        logic [CAP_W-1:0] nominal;
        logic [PM_W-1:0]  soc_step;
        logic [CAP_W-1:0] cap_step;
        logic [CAP_W-1:0] st_rem;
        logic [CAP_W-1:0] st_tot;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [CAP_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] quot;
    } t_div_rsp;

endpackage

### hdl/bcst_cfg.sv
// ---------------------------------------------------------------------------
// bcst_cfg
// Configuration register file with write decode.
// ---------------------------------------------------------------------------
module bcst_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bcst_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bcst_pkg::CAP_W-1:0]     i_cfg_data,
    output bcst_pkg::t_cfg                 o_cfg
);
    import bcst_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nominal  <= 16'd10000;
            r_cfg.soc_step <= 10'd10;
            r_cfg.cap_step <= 16'd100;
            r_cfg.st_rem   <= '0;
            r_cfg.st_tot   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NOMINAL:  r_cfg.nominal  <= i_cfg_data;
                CFG_SOC_STEP: r_cfg.soc_step <= i_cfg_data[PM_W-1:0];
                CFG_CAP_STEP: r_cfg.cap_step <= i_cfg_data;
                CFG_ST_REM:   r_cfg.st_rem   <= i_cfg_data;
                CFG_ST_TOT:   r_cfg.st_tot   <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

### hdl/bcst_div.sv
// ---------------------------------------------------------------------------
// bcst_div
// Restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
// ---------------------------------------------------------------------------
module bcst_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bcst_pkg::t_div_req i_req,
    output bcst_pkg::t_div_rsp o_rsp
);
    import bcst_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    logic [CAP_W-1:0]  r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [CAP_W-1:0]  r_dsr;
    logic [CAP_W:0]    shifted;
    logic              fits;

    assign shifted = {r_rem, r_quo[WORD_W-1]};
    assign fits    = shifted >= {1'b0, r_dsr};

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == 5'd31);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? 16'(shifted - {1'b0, r_dsr}) : shifted[CAP_W-1:0];
            r_quo <= {r_quo[WORD_W-2:0], fits};
        end
    end

endmodule

### hdl/battery_coulomb_soc_tracker_core.sv
// ---------------------------------------------------------------------------
// battery_coulomb_soc_tracker_core
// Coulomb counting state of charge tracker with a shared serial divider.
// ---------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with one port per field. An item
// is taken when valid is high and stall is low; stall stays high while an
// item is being worked on.
// Output channel: o_out_valid / i_out_stall; one result per item, held in
// an output register until the receiver drops stall. The next item may be
// accepted while a result still waits.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index, i_cfg_data;
// ready is always high. Write only while the block is idle.
// Divisions: each one uses the single restoring divider after operand setup.
// Per item: compute ticks take 4 divisions, nonzero-total corrections by
// total 3 (also low-temp), by SOC 2, others 1 (also with a record step);
// the block returns to idle before the next item is accepted.
// Reset: clears the tracker state, except the ratio and energy scratch registers, and loads the default configuration.
// A stalled receiver holds the result; a finished item waits in the last
// state until the output register is free.
// ---------------------------------------------------------------------------
module battery_coulomb_soc_tracker_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bcst_pkg::FUNC_W-1:0] i_func,
    input  logic signed [31:0]          i_charge_counter,
    input  logic [31:0]                 i_discharge_total,
    input  logic                        i_hold_soh,
    input  logic [bcst_pkg::PM_W-1:0]   i_target_soc,
    input  logic [bcst_pkg::CAP_W-1:0]  i_new_total,
    input  logic [bcst_pkg::CAP_W-1:0]  i_pack_voltage,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bcst_pkg::CAP_W-1:0]  o_remaining_cap,
    output logic [bcst_pkg::CAP_W-1:0]  o_total_cap,
    output logic [bcst_pkg::PM_W-1:0]   o_soc_permille,
    output logic [bcst_pkg::PM_W-1:0]   o_soh_permille,
    output logic [bcst_pkg::CAP_W-1:0]  o_cycle_count,
    output logic [bcst_pkg::CAP_W-1:0]  o_remain_energy,
    output logic                        o_save_remaining,
    output logic                        o_save_total,
    output logic                        o_save_calib,
    output logic [bcst_pkg::CAP_W-1:0]  o_calib_cycles,
    output logic                        o_published,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bcst_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bcst_pkg::CAP_W-1:0]  i_cfg_data
);
    import bcst_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        ST_IDLE, ST_PRE, ST_MUL, ST_DIV, ST_REC, ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        J_SOC, J_SOH, J_CYC, J_RATIO, J_NC, J_CORR, J_ENERGY
    } t_job;

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    t_state r_state;
    t_job   r_job;

    logic [FUNC_W-1:0]  r_func;
    logic [WORD_W-1:0]  r_ctr;
    logic [WORD_W-1:0]  r_dis;
    logic               r_hold;
    logic [PM_W-1:0]    r_tsoc;
    logic [CAP_W-1:0]   r_ntot;
    logic [CAP_W-1:0]   r_volt;

    logic [CAP_W-1:0]   r_now;
    logic [CAP_W-1:0]   r_top;
    logic [WORD_W-1:0]  r_last;
    logic               r_phase;
    logic [PM_W-1:0]    r_soc;
    logic [PM_W-1:0]    r_soh;
    logic [CAP_W-1:0]   r_cyc;
    logic [CAP_W-1:0]   r_cal;
    logic [PM_W-1:0]    r_sv_soc;
    logic [CAP_W-1:0]   r_sv_rem;
    logic [RATIO_W-1:0] r_ratio;
    logic [CAP_W-1:0]   r_energy;
    logic               r_f_rem;
    logic               r_f_tot;
    logic               r_pub;

    logic               r_div_start;
    logic [WORD_W-1:0]  r_dividend;
    logic [CAP_W-1:0]   r_divisor;

    logic               r_out_valid;
    logic [CAP_W-1:0]   r_o_rem;
    logic [CAP_W-1:0]   r_o_tot;
    logic [PM_W-1:0]    r_o_soc;
    logic [PM_W-1:0]    r_o_soh;
    logic [CAP_W-1:0]   r_o_cyc;
    logic [CAP_W-1:0]   r_o_energy;
    logic               r_o_f_rem;
    logic               r_o_f_tot;
    logic [CAP_W-1:0]   r_o_cal;
    logic               r_o_pub;

    logic               in_xfer;
    logic               out_free;

    logic [CAP_W-1:0]   mul_a;
    logic [CAP_W-1:0]   mul_b;
    logic [WORD_W-1:0]  product;
    logic [CAP_W-1:0]   dsr_sel;

    logic [WORD_W-1:0]  step_d;
    logic [WORD_W-1:0]  step_mag;
    logic               step_ok;
    logic [CAP_W:0]     acc_val;
    logic [CAP_W-1:0]   tick_now;

    logic [PM_W-1:0]    soc_diff;
    logic [CAP_W-1:0]   rem_diff;
    logic               rec_hit;
    logic [WORD_W-1:0]  quot;

    bcst_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign div_req.start    = r_div_start;
    assign div_req.dividend = r_dividend;
    assign div_req.divisor  = r_divisor;

    bcst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign quot       = div_rsp.quot;
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        mul_a   = r_now;
        mul_b   = PERMILLE;
        dsr_sel = r_top;
        case (r_job)
            J_SOC: begin
                mul_a = r_now; mul_b = PERMILLE; dsr_sel = r_top;
            end
            J_SOH: begin
                mul_a = r_top; mul_b = PERMILLE; dsr_sel = cfg.nominal;
            end
            J_CYC: begin
                mul_a = r_now; mul_b = PERMILLE; dsr_sel = cfg.nominal;
            end
            J_RATIO: begin
                mul_a = r_now; mul_b = RATIO_ONE; dsr_sel = r_top;
            end
            J_NC: begin
                mul_a = r_ntot; mul_b = {2'b00, r_ratio}; dsr_sel = RATIO_ONE;
            end
            J_CORR: begin
                mul_a = r_top; mul_b = {6'd0, r_tsoc}; dsr_sel = PERMILLE;
            end
            default: begin
                mul_a = r_now; mul_b = r_volt; dsr_sel = RATIO_ONE;
            end
        endcase
    end

    assign product = {16'd0, mul_a} * {16'd0, mul_b};

    assign step_d   = r_ctr - r_last;
    assign step_mag = step_d[WORD_W-1] ? (~step_d + 32'd1) : step_d;
    assign step_ok  = step_mag <= {16'd0, cfg.nominal};

    always_comb begin
        if (!step_ok) begin
            acc_val = {1'b0, r_now};
        end else if (step_d[WORD_W-1]) begin
            acc_val = (step_mag[CAP_W-1:0] > r_now) ? '0
                    : {1'b0, r_now - step_mag[CAP_W-1:0]};
        end else begin
            acc_val = {1'b0, r_now} + {1'b0, step_mag[CAP_W-1:0]};
        end
        tick_now = (acc_val > {1'b0, r_top}) ? r_top : acc_val[CAP_W-1:0];
    end

    assign soc_diff = (r_soc >= r_sv_soc) ? r_soc - r_sv_soc : r_sv_soc - r_soc;
    assign rem_diff = (r_now >= r_sv_rem) ? r_now - r_sv_rem : r_sv_rem - r_now;
    assign rec_hit  = (soc_diff >= cfg.soc_step) || (rem_diff >= cfg.cap_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_job       <= J_ENERGY;
            r_now       <= '0;
            r_top       <= '0;
            r_last      <= '0;
            r_phase     <= 1'b0;
            r_soc       <= '0;
            r_soh       <= '0;
            r_cyc       <= '0;
            r_cal       <= '0;
            r_sv_soc    <= '0;
            r_sv_rem    <= '0;
            r_f_rem     <= 1'b0;
            r_f_tot     <= 1'b0;
            r_pub       <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= (r_state == ST_MUL);
            if (r_out_valid && !i_out_stall && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_func  <= i_func;
                        r_ctr   <= i_charge_counter;
                        r_dis   <= i_discharge_total;
                        r_hold  <= i_hold_soh;
                        r_tsoc  <= i_target_soc;
                        r_ntot  <= i_new_total;
                        r_volt  <= i_pack_voltage;
                        r_f_rem <= 1'b0;
                        r_f_tot <= 1'b0;
                        r_pub   <= 1'b0;
                        r_state <= ST_PRE;
                    end
                end
                ST_PRE: begin
                    case (r_func)
                        FN_INIT: begin
                            if (cfg.st_rem > cfg.st_tot) begin
                                r_now <= {1'b0, cfg.nominal[CAP_W-1:1]};
                                r_top <= cfg.nominal;
                            end else begin
                                r_now <= cfg.st_rem;
                                r_top <= (cfg.st_tot == '0) ? cfg.nominal : cfg.st_tot;
                            end
                            r_job   <= J_ENERGY;
                            r_state <= ST_MUL;
                        end
                        FN_TICK: begin
                            if (!r_phase) begin
                                r_now   <= tick_now;
                                r_last  <= r_ctr;
                                r_phase <= 1'b1;
                                r_job   <= J_SOC;
                                r_state <= ST_MUL;
                            end else begin
                                r_phase <= 1'b0;
                                r_pub   <= 1'b1;
                                r_job   <= J_ENERGY;
                                r_state <= ST_REC;
                            end
                        end
                        FN_CORR_SOC: begin
                            r_job   <= (r_top != '0) ? J_CORR : J_ENERGY;
                            r_state <= ST_MUL;
                        end
                        FN_CORR_TOT, FN_CORR_TOT_L: begin
                            if (r_func == FN_CORR_TOT) begin
                                r_cal   <= r_cyc;
                                r_f_tot <= 1'b1;
                                r_pub   <= 1'b1;
                            end
                            if (r_top == '0) begin
                                r_now   <= '0;
                                r_job   <= J_ENERGY;
                                r_state <= (r_func == FN_CORR_TOT) ? ST_REC : ST_MUL;
                            end else begin
                                r_job   <= J_RATIO;
                                r_state <= ST_MUL;
                            end
                        end
                        default: begin
                            r_job   <= J_ENERGY;
                            r_state <= ST_MUL;
                        end
                    endcase
                end
                ST_MUL: begin
                    r_dividend  <= (r_job == J_CYC) ? r_dis : product;
                    r_divisor   <= dsr_sel;
                    r_state     <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        unique case (r_job)
                            J_SOC: begin
                                if (r_now >= r_top) begin
                                    r_soc <= PM_FULL;
                                end else if (r_now == '0) begin
                                    r_soc <= '0;
                                end else begin
                                    r_soc <= quot[PM_W-1:0];
                                end
                                r_job   <= J_SOH;
                                r_state <= ST_MUL;
                            end
                            J_SOH: begin
                                if (cfg.nominal[CAP_W-1:1] == '0) begin
                                    r_soh <= '0;
                                end else if (!r_hold) begin
                                    r_soh <= (quot > 32'd1000) ? PM_FULL : quot[PM_W-1:0];
                                end
                                r_job   <= J_CYC;
                                r_state <= ST_MUL;
                            end
                            J_CYC: begin
                                r_cyc <= (cfg.nominal == '0) ? 16'hFFFF : quot[CAP_W-1:0];
                                r_job   <= J_ENERGY;
                                r_state <= ST_MUL;
                            end
                            J_RATIO: begin
                                if (r_now >= r_top) begin
                                    r_ratio <= RATIO_ONE[RATIO_W-1:0];
                                end else if (r_now == '0) begin
                                    r_ratio <= '0;
                                end else begin
                                    r_ratio <= quot[RATIO_W-1:0];
                                end
                                r_job   <= J_NC;
                                r_state <= ST_MUL;
                            end
                            J_NC: begin
                                r_now <= (quot > {16'd0, r_ntot}) ? r_ntot : quot[CAP_W-1:0];
                                r_top <= r_ntot;
                                r_job <= J_ENERGY;
                                r_state <= (r_func == FN_CORR_TOT) ? ST_REC : ST_MUL;
                            end
                            J_CORR: begin
                                r_now <= (quot > {16'd0, r_top}) ? r_top : quot[CAP_W-1:0];
                                r_soc <= (r_tsoc > PM_FULL) ? PM_FULL : r_tsoc;
                                r_pub <= 1'b1;
                                r_job <= J_ENERGY;
                                r_state <= ST_REC;
                            end
                            J_ENERGY: begin
                                r_energy <= quot[CAP_W-1:0];
                                r_state  <= ST_DONE;
                            end
                            default: r_state <= ST_MUL;
                        endcase
                    end
                end
                ST_REC: begin
                    if (rec_hit) begin
                        r_sv_soc <= r_soc;
                        r_sv_rem <= r_now;
                        r_f_rem  <= 1'b1;
                    end
                    r_job   <= J_ENERGY;
                    r_state <= ST_MUL;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_rem     <= r_now;
                        r_o_tot     <= r_top;
                        r_o_soc     <= r_soc;
                        r_o_soh     <= r_soh;
                        r_o_cyc     <= r_cyc;
                        r_o_energy  <= r_energy;
                        r_o_f_rem   <= r_f_rem;
                        r_o_f_tot   <= r_f_tot;
                        r_o_cal     <= r_cal;
                        r_o_pub     <= r_pub;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_remaining_cap  = r_o_rem;
    assign o_total_cap      = r_o_tot;
    assign o_soc_permille   = r_o_soc;
    assign o_soh_permille   = r_o_soh;
    assign o_cycle_count    = r_o_cyc;
    assign o_remain_energy  = r_o_energy;
    assign o_save_remaining = r_o_f_rem;
    assign o_save_total     = r_o_f_tot;
    assign o_save_calib     = r_o_f_tot;
    assign o_calib_cycles   = r_o_cal;
    assign o_published      = r_o_pub;

    `ASSERT_IMPL(a_div_in_div_state, i_clk, i_rst_n, div_rsp.busy, r_state == ST_DIV)
    `ASSERT_NEXT(a_accept_stalls, i_clk, i_rst_n, in_xfer, o_in_stall)
    `ASSERT_NEXT(a_done_loads_out, i_clk, i_rst_n, (r_state == ST_DONE) && out_free, o_out_valid && (r_state == ST_IDLE))

endmodule

### tb/sv/tb_battery_coulomb_soc_tracker_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_battery_coulomb_soc_tracker_core
// Self-checking bench for the coulomb counting charge tracker. A queue of
// operations feeds a clocked driver with random gaps; a clocked monitor with
// random stall compares every result field by field with a software tracker
// that follows each accepted operation. Configuration is rewritten between
// phases while the block is idle.
// ---------------------------------------------------------------------------
module tb_battery_coulomb_soc_tracker_core;
    import bcst_pkg::*;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [31:0]       ctr;
        logic [31:0]       dis;
        logic              hold;
        logic [PM_W-1:0]   tsoc;
        logic [CAP_W-1:0]  ntot;
        logic [CAP_W-1:0]  volt;
    } t_op;

    typedef struct {
        logic [CAP_W-1:0] rem, tot;
        logic [PM_W-1:0]  soc, soh;
        logic [CAP_W-1:0] cyc, energy;
        logic             s_rem, s_tot, s_cal;
        logic [CAP_W-1:0] cal;
        logic             pub;
    } t_res;

    logic i_clk = 0, i_rst_n = 0;
    logic i_in_valid = 0, o_in_stall;
    logic [FUNC_W-1:0] i_func = 0;
    logic signed [31:0] i_charge_counter = 0;
    logic [31:0] i_discharge_total = 0;
    logic i_hold_soh = 0;
    logic [PM_W-1:0] i_target_soc = 0;
    logic [CAP_W-1:0] i_new_total = 0, i_pack_voltage = 0;
    logic o_out_valid, i_out_stall = 0;
    logic [CAP_W-1:0] o_remaining_cap, o_total_cap, o_cycle_count, o_remain_energy;
    logic [CAP_W-1:0] o_calib_cycles;
    logic [PM_W-1:0] o_soc_permille, o_soh_permille;
    logic o_save_remaining, o_save_total, o_save_calib, o_published;
    logic i_cfg_valid = 0, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = 0;
    logic [CAP_W-1:0] i_cfg_data = 0;

    battery_coulomb_soc_tracker_core dut (.*);

    // tracker copy
    int unsigned nom, soc_step, cap_step, st_rem, st_tot;
    int unsigned now_cap, top_cap, last_ctr, phase;
    int unsigned soc_v, soh_v, cyc_v, cal_v, sv_soc, sv_rem, sv_tot;

    t_op  pending_ops[$];
    t_res expected_results[$];
    int   errors = 0;
    int   cycles = 0;
    bit   hold_sender = 0;
    int   send_gap = 0, recv_gap = 0;
    logic [31:0] last_queued_ctr = 0;

    function automatic int unsigned adiff(int unsigned a, int unsigned b);
        return a >= b ? a - b : b - a;
    endfunction

    function automatic bit note_remaining();
        if (adiff(soc_v, sv_soc) >= soc_step || adiff(now_cap, sv_rem) >= cap_step) begin
            sv_soc = soc_v;
            sv_rem = now_cap;
            return 1;
        end
        return 0;
    endfunction

    function automatic void rescale(int unsigned cap);
        int unsigned ratio;
        longint unsigned nc;
        if (top_cap == 0) begin
            now_cap = 0;
            top_cap = 0;
            return;
        end
        if (now_cap >= top_cap) ratio = 10000;
        else if (now_cap == 0) ratio = 0;
        else ratio = now_cap * 10000 / top_cap;
        nc = longint'(cap) * ratio / 10000;
        if (nc > cap) nc = cap;
        now_cap = nc[15:0];
        top_cap = cap & 16'hFFFF;
    endfunction

    function automatic t_res track_op(t_op op);
        t_res r;
        bit s_rem = 0, s_tot = 0, s_cal = 0, pub = 0;
        int unsigned d, soh, nc32, t;
        longint nc;
        longint delta;
        case (op.func)
            FN_INIT: begin
                now_cap = st_rem;
                top_cap = st_tot;
                if (now_cap > top_cap) begin
                    now_cap = nom / 2;
                    top_cap = nom;
                end
                if (top_cap == 0) top_cap = nom;
            end
            FN_TICK: begin
                if (phase == 0) begin
                    d = op.ctr - last_ctr;
                    delta = longint'($signed(d));
                    if (delta > longint'(nom) || delta < -longint'(nom)) delta = 0;
                    nc = longint'(now_cap) + delta;
                    if (nc > longint'(top_cap)) nc = longint'(top_cap);
                    if (nc < 0) nc = 0;
                    now_cap = 32'(nc);
                    last_ctr = op.ctr;
                    if (now_cap >= top_cap) soc_v = 1000;
                    else if (now_cap == 0) soc_v = 0;
                    else soc_v = now_cap * 1000 / top_cap;
                    if (nom > 1) begin
                        soh = op.hold ? soh_v : top_cap * 1000 / nom;
                        soh_v = soh > 1000 ? 1000 : soh;
                    end else begin
                        soh_v = 0;
                    end
                    cyc_v = (nom == 0) ? 16'hFFFF : (op.dis / nom) & 16'hFFFF;
                    phase = 1;
                end else begin
                    s_rem = note_remaining();
                    pub = 1;
                    phase = 0;
                end
            end
            FN_CORR_SOC: begin
                if (top_cap != 0) begin
                    t = op.tsoc;
                    nc32 = top_cap * t / 1000;
                    if (nc32 > top_cap) nc32 = top_cap;
                    now_cap = nc32;
                    soc_v = t > 1000 ? 1000 : t;
                    s_rem = note_remaining();
                    pub = 1;
                end
            end
            FN_CORR_TOT: begin
                rescale(op.ntot);
                cal_v = cyc_v;
                s_cal = 1;
                s_tot = 1;
                sv_tot = top_cap;
                s_rem = note_remaining();
                pub = 1;
            end
            FN_CORR_TOT_L: rescale(op.ntot);
            default: ;
        endcase
        r.rem = CAP_W'(now_cap); r.tot = CAP_W'(top_cap);
        r.soc = PM_W'(soc_v); r.soh = PM_W'(soh_v);
        r.cyc = CAP_W'(cyc_v);
        r.energy = CAP_W'((now_cap * op.volt) / 10000);
        r.s_rem = s_rem; r.s_tot = s_tot; r.s_cal = s_cal;
        r.cal = CAP_W'(cal_v); r.pub = pub;
        return r;
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        t_op op;
        cycles <= cycles + 1;
        if (i_in_valid && !o_in_stall) begin
            expected_results.push_back(track_op(pending_ops.pop_front()));
            send_gap = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) send_gap = 0;
        end
        if (!i_in_valid || !o_in_stall) begin
            if (send_gap > 0) send_gap--;
            if (pending_ops.size() > 0 && send_gap == 0 && !hold_sender && i_rst_n) begin
                op = pending_ops[0];
                i_in_valid <= 1;
                i_func <= op.func;
                i_charge_counter <= op.ctr;
                i_discharge_total <= op.dis;
                i_hold_soh <= op.hold;
                i_target_soc <= op.tsoc;
                i_new_total <= op.ntot;
                i_pack_voltage <= op.volt;
            end else begin
                i_in_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        if (o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result");
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_remaining_cap !== e.rem) begin
                    $error("remaining_cap exp %0d got %0d", e.rem, o_remaining_cap); errors++;
                end
                if (o_total_cap !== e.tot) begin
                    $error("total_cap exp %0d got %0d", e.tot, o_total_cap); errors++;
                end
                if (o_soc_permille !== e.soc) begin
                    $error("soc_permille exp %0d got %0d", e.soc, o_soc_permille); errors++;
                end
                if (o_soh_permille !== e.soh) begin
                    $error("soh_permille exp %0d got %0d", e.soh, o_soh_permille); errors++;
                end
                if (o_cycle_count !== e.cyc) begin
                    $error("cycle_count exp %0d got %0d", e.cyc, o_cycle_count); errors++;
                end
                if (o_remain_energy !== e.energy) begin
                    $error("remain_energy exp %0d got %0d", e.energy, o_remain_energy);
                    errors++;
                end
                if (o_save_remaining !== e.s_rem) begin
                    $error("save_remaining exp %0d got %0d", e.s_rem, o_save_remaining);
                    errors++;
                end
                if (o_save_total !== e.s_tot) begin
                    $error("save_total exp %0d got %0d", e.s_tot, o_save_total); errors++;
                end
                if (o_save_calib !== e.s_cal) begin
                    $error("save_calib exp %0d got %0d", e.s_cal, o_save_calib); errors++;
                end
                if (o_calib_cycles !== e.cal) begin
                    $error("calib_cycles exp %0d got %0d", e.cal, o_calib_cycles); errors++;
                end
                if (o_published !== e.pub) begin
                    $error("published exp %0d got %0d", e.pub, o_published); errors++;
                end
            end
            recv_gap = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) recv_gap = 0;
        end
        if (recv_gap > 0) begin
            recv_gap--;
            i_out_stall <= 1;
        end else begin
            i_out_stall <= 0;
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 2000000) begin
            $display("** battery_coulomb_soc_tracker_core: FAILED **");
            $finish;
        end
    end

    task automatic add_op(logic [FUNC_W-1:0] f, logic [31:0] c, logic [31:0] d, logic h,
                          logic [PM_W-1:0] s, logic [CAP_W-1:0] n, logic [CAP_W-1:0] v);
        t_op op;
        op.func = f; op.ctr = c; op.dis = d; op.hold = h;
        op.tsoc = s; op.ntot = n; op.volt = v;
        pending_ops.push_back(op);
    endtask

    task automatic add_random_op(int unsigned span);
        logic [FUNC_W-1:0] f;
        logic [31:0] c;
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 60) f = FN_TICK;
        else if (k < 70) f = FN_CORR_SOC;
        else if (k < 78) f = FN_CORR_TOT;
        else if (k < 85) f = FN_CORR_TOT_L;
        else if (k < 92) f = FN_INIT;
        else f = FUNC_W'($urandom_range(5, 7));
        if ($urandom_range(0, 9) == 0) c = $urandom;
        else c = last_queued_ctr + $urandom_range(0, 2 * span) - span;
        last_queued_ctr = c;
        add_op(f, c, $urandom, 1'($urandom_range(0, 1)),
               ($urandom_range(0, 4) == 0) ? PM_W'($urandom) : PM_W'($urandom_range(0, 1000)),
               ($urandom_range(0, 3) == 0) ? CAP_W'($urandom) : CAP_W'($urandom_range(0, 20000)),
               CAP_W'($urandom));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_NOMINAL:  nom = val;
            CFG_SOC_STEP: soc_step = val[PM_W-1:0];
            CFG_CAP_STEP: cap_step = val;
            CFG_ST_REM:   st_rem = val;
            CFG_ST_TOT:   st_tot = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_ops.size() > 0 || expected_results.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic setup(int unsigned n, int unsigned sst, int unsigned cst,
                         int unsigned sr, int unsigned stt);
        write_reg(CFG_NOMINAL, CAP_W'(n));
        write_reg(CFG_SOC_STEP, CAP_W'(sst));
        write_reg(CFG_CAP_STEP, CAP_W'(cst));
        write_reg(CFG_ST_REM, CAP_W'(sr));
        write_reg(CFG_ST_TOT, CAP_W'(stt));
        i_cfg_valid <= 0;
    endtask

    initial begin
        nom = 10000; soc_step = 10; cap_step = 100; st_rem = 0; st_tot = 0;
        {now_cap, top_cap, last_ctr, phase} = '0;
        {soc_v, soh_v, cyc_v, cal_v, sv_soc, sv_rem, sv_tot} = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: defaults, zero total before init, fallbacks, jumps, extremes
        add_op(FN_CORR_SOC, 0, 0, 0, 500, 0, 0);
        add_op(FN_CORR_TOT, 0, 0, 0, 0, 5000, 0);
        add_op(FN_INIT, 0, 0, 0, 0, 0, 16'hFFFF);
        add_op(FN_TICK, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 16'hFFFF);
        add_op(FN_TICK, 0, 0, 0, 0, 0, 0);
        add_op(FN_TICK, 32'h8000_0000, 0, 1, 0, 0, 100);
        add_op(FN_TICK, 0, 0, 0, 0, 0, 0);
        add_op(FN_CORR_SOC, 0, 0, 0, 10'h3FF, 0, 16'hFFFF);
        add_op(FN_CORR_SOC, 0, 0, 0, 0, 0, 1);
        add_op(FN_TICK, 32'hFFFF_FFFF, 12345, 1, 0, 0, 3000);
        add_op(FN_TICK, 0, 0, 0, 0, 0, 0);
        add_op(FN_CORR_TOT, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF);
        add_op(FN_CORR_TOT_L, 0, 0, 0, 0, 0, 1);
        add_op(FN_CORR_TOT, 0, 0, 0, 0, 8000, 0);
        add_op(3'd5, 0, 0, 0, 0, 0, 0);
        add_op(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 10'h3FF, 16'hFFFF, 16'hFFFF);
        drain();

        setup(1000, 0, 0, 900, 800);
        add_op(FN_INIT, 0, 0, 0, 0, 0, 0);
        add_op(FN_TICK, 500, 5000, 0, 0, 0, 4000);
        add_op(FN_TICK, 0, 0, 0, 0, 0, 0);
        add_op(FN_TICK, 1501, 5000, 0, 0, 0, 4000);
        drain();
        last_queued_ctr = last_ctr;

        for (int phase_i = 0; phase_i < 6; phase_i++) begin
            case (phase_i)
                0: setup(10000, 10, 100, 7000, 9000);
                1: setup(65535, 1000, 65535, 65535, 65535);
                2: setup(1, 0, 0, 0, 0);
                3: setup(0, 1, 1, 5, 3);
                4: setup(3000, 5, 50, 1000, 6000);
                default: setup($urandom_range(2, 65535), $urandom_range(0, 1000),
                                $urandom, $urandom, $urandom);
            endcase
            add_op(FN_INIT, 0, 0, 0, 0, 0, 0);
            for (int i = 0; i < 65; i++) begin
                add_random_op(nom < 4 ? 8 : nom + nom / 8);
                if (phase_i == 3 && i == 30) begin
                    while (pending_ops.size() > 16) @(posedge i_clk);
                    hold_sender = 1;
                    while (i_in_valid || expected_results.size() > 0) @(posedge i_clk);
                    hold_sender = 0;
                end
            end
            drain();
            last_queued_ctr = last_ctr;
        end

        if (errors == 0) begin
            $display("** battery_coulomb_soc_tracker_core: PASSED **");
        end else begin
            $display("** battery_coulomb_soc_tracker_core: FAILED **");
        end
        $finish;
    end

endmodule

### battery_coulomb_soc_tracker_core.f
+incdir+hdl
hdl/bcst_pkg.sv
hdl/bcst_cfg.sv
hdl/bcst_div.sv
hdl/battery_coulomb_soc_tracker_core.sv
tb/sv/tb_battery_coulomb_soc_tracker_core.sv
